>>> rtl/fcf_pkg.sv
// shared types and constants for the fir convolution filter
`timescale 1ns / 1ps

package fcf_pkg;

    localparam int VALUE_W = 16;
    localparam int PROD_W  = 32;
    localparam int OUT_W   = 42;
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 11;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_FILTER = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic acc_clr;    // start a new sum
        logic mul_en;     // read data from both memories is valid
        logic sample_ok;  // history entry was written since the last clear
    } t_mac_ctrl;

endpackage

>>> rtl/fcf_ram.sv
// single write port, single read port memory with registered read data
`timescale 1ns / 1ps

module fcf_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/fcf_mac.sv
// multiply-accumulate unit: registered product, then wrapping accumulate
`timescale 1ns / 1ps

module fcf_mac
    import fcf_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_mac_ctrl                 i_ctrl,
    input  logic signed [VALUE_W-1:0] i_coef,
    input  logic signed [VALUE_W-1:0] i_sample,
    output logic signed [OUT_W-1:0]   o_acc,
    output logic                      o_busy
);

    logic signed [VALUE_W-1:0] w_sample;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_prod_vld;
    logic signed [OUT_W-1:0]   r_acc;

    // entries not written since the last clear read as zero
    assign w_sample = i_ctrl.sample_ok ? i_sample : '0;
    assign n_prod   = i_coef * w_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctrl.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= n_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc_clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + OUT_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_prod_vld;

endmodule

>>> rtl/fir_convolution_filter_core.sv
// direct-form fir filter top level: request decode, tap sequencer and output register
// filter steps: accept and write the sample, issue the taps (S_RUN), drain the products (S_DRAIN), result (S_FINISH)
// throughput: no new filter request until the previous one is finished, one tap per cycle through the shared
//   multiply-accumulate; a finished sum waits while the previous result is not yet taken
// load, clear and unused requests leave the sequencer idle and give no result
// reset (i_rst_n low, synchronous): tap count 1, history empty, pointer 0, no result
// the coefficient memory is undefined until loaded; history needs no clearing pass
`timescale 1ns / 1ps

module fir_convolution_filter_core
    import fcf_pkg::*;
#(
    parameter int MAX_TAPS = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [CNT_W-1:0]          i_cfg_data,
    // request channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [OP_W-1:0]           i_operation,
    input  logic [IDX_W-1:0]          i_tap_index,
    input  logic signed [VALUE_W-1:0] i_value,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [OUT_W-1:0]   o_filtered_value
);

    localparam int AW = $clog2(MAX_TAPS);
    localparam int CW = $clog2(MAX_TAPS + 1);
    localparam logic [AW-1:0] LAST_POS = AW'(MAX_TAPS - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_TAPS);

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RUN    = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_tap_count;
    logic [AW-1:0]    r_ptr, n_ptr;        // next history slot to write
    logic [CW-1:0]    r_fill, n_fill;      // samples written since clear, saturating
    logic [CW-1:0]    r_taps, n_taps;      // taps used by the running sample
    logic [CW-1:0]    r_k, n_k;            // tap being issued
    logic [AW-1:0]    r_pos, n_pos;        // history slot being issued
    logic             r_s1_vld, r_s1_ok;   // read data stage
    logic             r_out_valid;
    logic signed [OUT_W-1:0] r_out_data;

    logic             w_accept;
    logic             w_issue;
    logic             w_coef_we, w_hist_we;
    logic [31:0]      w_idx32;
    logic [31:0]      w_tc32;
    logic [AW-1:0]    w_coef_waddr;
    logic signed [VALUE_W-1:0] w_coef, w_sample;
    logic signed [OUT_W-1:0]   w_acc;
    logic             w_mac_busy;
    t_mac_ctrl        w_mac_ctrl;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // load index widened so depths above and below 1024 both work
    assign w_idx32      = 32'(i_tap_index);
    assign w_coef_waddr = w_idx32[AW-1:0];
    assign w_coef_we    = w_accept && (i_operation == OP_LOAD)
                          && (w_idx32 < 32'(MAX_TAPS));
    assign w_hist_we    = w_accept && (i_operation == OP_FILTER);

    // tap count saturates at the memory depth
    assign w_tc32 = 32'(r_tap_count);

    assign w_issue = (r_state == S_RUN) && (r_k < r_taps);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= CNT_W'(1);
        end else if (i_cfg_we) begin
            r_tap_count <= i_cfg_data;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_fill  = r_fill;
        n_taps  = r_taps;
        n_k     = r_k;
        n_pos   = r_pos;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_operation)
                        OP_FILTER: begin
                            // sample goes into the slot at the pointer, walk starts there
                            n_state = S_RUN;
                            n_pos   = r_ptr;
                            n_k     = '0;
                            n_ptr   = (r_ptr == LAST_POS) ? '0 : r_ptr + 1'b1;
                            n_fill  = (r_fill == FULL_CNT) ? r_fill : r_fill + 1'b1;
                            n_taps  = (w_tc32 > 32'(MAX_TAPS)) ? FULL_CNT
                                                               : w_tc32[CW-1:0];
                        end
                        OP_CLEAR: begin
                            n_ptr  = '0;
                            n_fill = '0;
                        end
                        default: begin
                            // load handled by the memory write, unused code ignored
                        end
                    endcase
                end
            end
            S_RUN: begin
                if (w_issue) begin
                    n_k   = r_k + 1'b1;
                    n_pos = (r_pos == '0) ? LAST_POS : r_pos - 1'b1;
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // wait until the last product has been added
                if (!r_s1_vld && !w_mac_busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ptr    <= '0;
            r_fill   <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_fill   <= n_fill;
            r_s1_vld <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_taps  <= n_taps;
        r_k     <= n_k;
        r_pos   <= n_pos;
        r_s1_ok <= r_k < r_fill;
    end

    // coefficient memory, read by tap number
    fcf_ram #(
        .DEPTH (MAX_TAPS),
        .AW    (AW),
        .DW    (VALUE_W)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (w_coef_waddr),
        .i_wdata (i_value),
        .i_re    (w_issue),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (w_coef)
    );

    // sample history ring, read backward from the newest sample
    fcf_ram #(
        .DEPTH (MAX_TAPS),
        .AW    (AW),
        .DW    (VALUE_W)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (r_ptr),
        .i_wdata (i_value),
        .i_re    (w_issue),
        .i_raddr (r_pos),
        .o_rdata (w_sample)
    );

    assign w_mac_ctrl.acc_clr   = w_hist_we;
    assign w_mac_ctrl.mul_en    = r_s1_vld;
    assign w_mac_ctrl.sample_ok = r_s1_ok;

    fcf_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_mac_ctrl),
        .i_coef   (w_coef),
        .i_sample (w_sample),
        .o_acc    (w_acc),
        .o_busy   (w_mac_busy)
    );

    // output register, frees the sequencer while a result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FINISH) && (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FINISH) && (!r_out_valid || i_out_ready)) begin
            r_out_data <= w_acc;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_filtered_value = r_out_data;

endmodule
